FILE: design/afm_pkg.sv
// Shared types and constants of the averaging frequency meter.
package afm_pkg;

	localparam int CNT_W       = 16;
	localparam int TICK_W      = 16;
	localparam int TOL_W       = 8;
	localparam int HIST_DEPTH  = 10;
	localparam int HIST_AW     = $clog2(HIST_DEPTH);
	localparam int SUM_W       = 20;
	localparam int SCALED_W    = 23;
	localparam int NUM_DIGITS  = 8;
	localparam int DIG_W       = 4;
	localparam int BCD_W       = NUM_DIGITS * DIG_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CNT_W-1:0]  CNT_MAX          = '1;
	localparam logic [TICK_W-1:0] GATE_TICKS_RST   = 16'd1000;
	localparam logic [TOL_W-1:0]  STABLE_TOL_RST   = 8'd1;

	// divide by ten: (v * RECIP10) >> RECIP_SHIFT is exact for v below 2^24
	localparam int                RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP10    = 24'd13421773;
	localparam int                RECIP_SHIFT = 27;
	localparam int                PROD_W      = SCALED_W + RECIP_W;

	localparam logic [CFG_IDX_W-1:0] REG_GATE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_TOL = 2'd1;

	typedef struct packed {
		logic ref_tick;
		logic sig_edge;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]    latest_count;
		logic [SCALED_W-1:0] scaled_sum;
		logic [BCD_W-1:0]    bcd_digits;
		logic [NUM_DIGITS-1:0] blank_mask;
		logic                stable;
		logic                overrange;
	} out_item_t;

	// gate close event from the counter front end
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             overrange;
	} close_ev_t;

	// history stage result toward the digit pipeline
	typedef struct packed {
		logic [CNT_W-1:0] latest_count;
		logic [SUM_W-1:0] mean_sum;
		logic             stable;
		logic             overrange;
	} hist_res_t;

	// fields carried alongside the digit pipeline
	typedef struct packed {
		logic [CNT_W-1:0] latest_count;
		logic             stable;
		logic             overrange;
	} side_t;

endpackage

FILE: design/afm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: design/afm_gate.sv
// Gate front end: reference tick and signal edge counters, gate close detect.
module afm_gate import afm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  in_item_t          item,
	input  logic [TICK_W-1:0] gate_ticks,
	output logic              close,
	output close_ev_t         ev
);

	logic [TICK_W-1:0] tick_q, tick_n;
	logic [CNT_W-1:0]  edge_q, edge_n;
	logic              sat_q, sat_n;

	always_comb begin
		edge_n = edge_q;
		sat_n  = sat_q;
		if (item.sig_edge) begin
			if (edge_q == CNT_MAX) begin
				sat_n = 1'b1;
			end else begin
				edge_n = edge_q + 1'b1;
			end
		end
		tick_n = item.ref_tick ? tick_q + 1'b1 : tick_q;
		// a zero gate length closes on every tick, same as one
		close = accept && item.ref_tick && (tick_n >= gate_ticks);
		ev.count     = edge_n;
		ev.overrange = sat_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
			edge_q <= '0;
			sat_q  <= 1'b0;
		end else if (accept) begin
			if (close) begin
				tick_q <= '0;
				edge_q <= '0;
				sat_q  <= 1'b0;
			end else begin
				tick_q <= tick_n;
				edge_q <= edge_n;
				sat_q  <= sat_n;
			end
		end
	end

endmodule

FILE: design/afm_hist.sv
// Count history in RAM: circular buffer, running sum and stability compare.
module afm_hist import afm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             close,
	input  close_ev_t        ev,
	input  logic [TOL_W-1:0] stable_tol,
	output logic             res_valid,
	output hist_res_t        res
);

	logic [HIST_AW-1:0]    wp_q, wp_nxt;
	logic [HIST_DEPTH-1:0] written_q;
	logic [SUM_W-1:0]      sum_q, sum_new;

	logic                  vld_s1;
	logic [HIST_AW-1:0]    wp_s1;
	close_ev_t             ev_s1;
	logic                  vdrop_s1, vold_s1;

	logic                  vld_s2;
	hist_res_t             res_s2;

	logic [CNT_W-1:0]      drop_rd, old_rd, drop_val, old_val, diff;
	logic                  wr_en;

	// wp_q holds the entry to drop (ten gates back); the one after it becomes the oldest
	assign wp_nxt = (wp_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign wr_en  = adv && vld_s1;

	afm_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_ram_drop (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_s1),
		.wr_data (ev_s1.count),
		.rd_en   (close),
		.rd_addr (wp_q),
		.rd_data (drop_rd)
	);

	afm_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_ram_old (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wp_s1),
		.wr_data (ev_s1.count),
		.rd_en   (close),
		.rd_addr (wp_nxt),
		.rd_data (old_rd)
	);

	always_comb begin
		drop_val = vdrop_s1 ? drop_rd : '0;
		old_val  = vold_s1 ? old_rd : '0;
		sum_new  = sum_q - SUM_W'(drop_val) + SUM_W'(ev_s1.count);
		diff     = (old_val >= ev_s1.count) ? old_val - ev_s1.count
			: ev_s1.count - old_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			written_q <= '0;
			sum_q     <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else if (adv) begin
			vld_s1 <= close;
			vld_s2 <= vld_s1;
			if (close) begin
				wp_q <= wp_nxt;
			end
			if (vld_s1) begin
				sum_q <= sum_new;
				written_q[wp_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (close) begin
				wp_s1    <= wp_q;
				ev_s1    <= ev;
				vdrop_s1 <= written_q[wp_q];
				vold_s1  <= written_q[wp_nxt];
			end
			res_s2.latest_count <= ev_s1.count;
			res_s2.mean_sum     <= sum_new;
			res_s2.stable       <= (diff <= CNT_W'(stable_tol));
			res_s2.overrange    <= ev_s1.overrange;
		end
	end

	assign res_valid = vld_s2;
	assign res       = res_s2;

endmodule

FILE: design/afm_bcd.sv
// Scale by ten, binary to BCD one digit per stage, blank mask, output register.
module afm_bcd import afm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      res_valid,
	input  hist_res_t res,
	output logic      result_valid,
	output out_item_t result
);

	logic [SCALED_W-1:0] v_q    [NUM_DIGITS+1];
	logic [SCALED_W-1:0] scl_q  [NUM_DIGITS+1];
	logic [BCD_W-1:0]    bcd_q  [NUM_DIGITS+1];
	side_t               side_q [NUM_DIGITS+1];
	logic [NUM_DIGITS:0] vld_q;

	logic [SCALED_W-1:0] quo    [NUM_DIGITS];
	logic [BCD_W-1:0]    bcd_n  [NUM_DIGITS];

	logic [SCALED_W-1:0] scaled;
	logic [NUM_DIGITS-1:0] mask;
	logic                nz_seen;

	logic                out_vld_q;
	out_item_t           out_q;

	// mean in hundredths: sum * 100 / 10 = sum * 10
	assign scaled = {res.mean_sum, 3'b000} + SCALED_W'({res.mean_sum, 1'b0});

	for (genvar j = 0; j < NUM_DIGITS; j++) begin : g_dig
		logic [PROD_W-1:0]   prod;
		logic [SCALED_W-1:0] rem;
		always_comb begin
			prod = PROD_W'(v_q[j]) * PROD_W'(RECIP10);
			quo[j] = SCALED_W'(prod >> RECIP_SHIFT);
			rem = v_q[j] - ({quo[j][SCALED_W-4:0], 3'b000} + {quo[j][SCALED_W-2:0], 1'b0});
			bcd_n[j] = bcd_q[j];
			bcd_n[j][DIG_W*j +: DIG_W] = rem[DIG_W-1:0];
		end
	end

	// digit zero is the bottom nibble; blanking runs from the top until the first nonzero digit
	always_comb begin
		nz_seen = 1'b0;
		mask = '0;
		for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
			if (bcd_q[NUM_DIGITS][DIG_W*i +: DIG_W] != '0) begin
				nz_seen = 1'b1;
			end
			mask[i] = !nz_seen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[NUM_DIGITS-1:0], res_valid};
			out_vld_q <= vld_q[NUM_DIGITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_q[0]   <= scaled;
			scl_q[0] <= scaled;
			bcd_q[0] <= '0;
			side_q[0].latest_count <= res.latest_count;
			side_q[0].stable       <= res.stable;
			side_q[0].overrange    <= res.overrange;
			for (int j = 0; j < NUM_DIGITS; j++) begin
				v_q[j+1]    <= quo[j];
				scl_q[j+1]  <= scl_q[j];
				bcd_q[j+1]  <= bcd_n[j];
				side_q[j+1] <= side_q[j];
			end
			out_q.latest_count <= side_q[NUM_DIGITS].latest_count;
			out_q.scaled_sum   <= scl_q[NUM_DIGITS];
			out_q.bcd_digits   <= bcd_q[NUM_DIGITS];
			out_q.blank_mask   <= mask;
			out_q.stable       <= side_q[NUM_DIGITS].stable;
			out_q.overrange    <= side_q[NUM_DIGITS].overrange;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule

FILE: design/averaging_frequency_meter.sv
// Averaging frequency meter: takes one item (reference tick, signal edge) per
// clock while item_stall is low and counts edges over a gate of gate_ticks
// reference ticks. Each gate close pushes the saturated count into a ten-entry
// history held in RAM and yields one result beat: the latest count, ten times
// the history sum (mean in hundredths), its eight BCD digits, a leading-zero
// blank mask, a stability flag and overrange. Items are taken every cycle while
// not stalled; a result passes from the item that closes its gate through the
// history read-modify-write (two stages), the scale stage and the eight-stage
// divide-by-ten digit pipeline, followed by the output register. Gates may
// close on consecutive items. While a result beat sits stalled at the output,
// the whole pipeline holds and item_stall is raised. cfg_ready is always high.
module averaging_frequency_meter import afm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  in_item_t              item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output out_item_t             result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic              adv;
	logic              accept;
	logic              close;
	close_ev_t         ev;
	logic              res_valid;
	hist_res_t         res;
	logic [TICK_W-1:0] gate_ticks_q;
	logic [TOL_W-1:0]  stable_tol_q;

	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;
	assign accept     = item_valid && adv;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gate_ticks_q <= GATE_TICKS_RST;
			stable_tol_q <= STABLE_TOL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GATE_TICKS: gate_ticks_q <= cfg_data[TICK_W-1:0];
				REG_STABLE_TOL: stable_tol_q <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	afm_gate u_gate (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.gate_ticks (gate_ticks_q),
		.close      (close),
		.ev         (ev)
	);

	afm_hist u_hist (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.close      (close),
		.ev         (ev),
		.stable_tol (stable_tol_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	afm_bcd u_bcd (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.res_valid    (res_valid),
		.res          (res),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

FILE: design/afm_checker.sv
// Port-level checks of the averaging frequency meter, bound to the top level.
module afm_checker import afm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      item_stall,
	input logic      result_valid,
	input logic      result_stall,
	input out_item_t result
);

	// a stalled result beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// input side backs up only behind a stalled result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall == (result_valid && result_stall))
		else $error("item_stall does not follow the output stall");

	// value is ten times a sum, so the last digit is zero
	a_lsd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.bcd_digits[3:0] == 4'd0)
		else $error("last BCD digit not zero");

	// top digit blank flag matches the top digit
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.blank_mask[7] == (result.bcd_digits[31:28] == 4'd0))
		else $error("blank mask disagrees with top digit");

	// zero reading blanks every digit
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.scaled_sum == '0 |->
			result.blank_mask == 8'hFF && result.bcd_digits == '0)
		else $error("zero reading not fully blanked");

endmodule

bind averaging_frequency_meter afm_checker u_afm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
